>>> rtl/outlier_reset_running_average_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the running average core
// Shared shorthand for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef OUTLIER_RESET_RUNNING_AVERAGE_CORE_DEFINES_SVH
`define OUTLIER_RESET_RUNNING_AVERAGE_CORE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define ORAA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the next clock edge.
`define ORAA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/oraa_pkg.sv
// ----------------------------------------------------------------------------
// Running average package
// Shared constants, sequencer states and control strobes.
// ----------------------------------------------------------------------------
`default_nettype none

package oraa_pkg;

  // Default widths of the datapath.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int COUNT_BITS_DEF  = 16;

  // A Q12.4 sample moves to the Q12.12 average domain by this shift.
  localparam int AVG_SHIFT = 8;

  // Deviation ratio register.
  localparam int          RATIO_BITS  = 12;
  localparam logic [11:0] RATIO_RESET = 12'd51;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic s_ready;
    logic mul;
    logic decide;
    logic update;
    logic m_valid;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/oraa_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oraa_div #(
  parameter int DIVIDEND_BITS = 24,
  parameter int DIVISOR_BITS  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [DIVISOR_BITS-1:0]  divisor,
  output logic                          done,
  output logic      [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     active;
  logic [CNT_BITS-1:0]      cnt;
  logic [DIVISOR_BITS-1:0]  dvsr;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS:0]    rem_shift;
  logic [DIVISOR_BITS:0]    diff;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_BITS-1]};
    diff      = rem_shift - {1'b0, dvsr};
  end

  // Step counter and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_BITS'(DIVIDEND_BITS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (active) begin
      if (!diff[DIVISOR_BITS]) begin
        rem <= diff[DIVISOR_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DIVISOR_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> rtl/oraa_ctrl.sv
// ----------------------------------------------------------------------------
// Running average sequencer
// Steps one item through multiply and compare, then divide and update unless it restarts.
// ----------------------------------------------------------------------------
`default_nettype none

module oraa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  input  wire logic           m_tready,
  input  wire logic           restart,
  input  wire logic           div_done,
  output oraa_pkg::ctrl_t     ctl
);

  import oraa_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = restart ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Strobes for the datapath.
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: ctl.s_ready = 1'b1;
      ST_MUL:  ctl.mul     = 1'b1;
      ST_CMP:  ctl.decide  = 1'b1;
      ST_UPD:  ctl.update  = 1'b1;
      ST_OUT:  ctl.m_valid = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/outlier_reset_running_average_core.sv
// ----------------------------------------------------------------------------
// Running average with outlier restart
// Cumulative average of distance samples that restarts on outliers.
// ----------------------------------------------------------------------------
// Each input item is one Q12.4 distance sample; each result item carries the
// new Q12.12 average, the number of samples behind it and a restart flag.
// The block works on one item at a time and drops s_tready from acceptance
// until its result is taken. A restarting item (zero average or a deviation
// above deviation_ratio times the average) goes through the multiply and
// compare states to its result; an updating item also passes through the
// divide and update states and waits on the restoring divider, which produces
// one quotient bit of the (SAMPLE_BITS + 8)-bit step per cycle. The sequencer
// returns to its idle state after a result is taken, before the next item.
`default_nettype none

`include "outlier_reset_running_average_core_defines.svh"

module outlier_reset_running_average_core #(
  parameter int SAMPLE_BITS = oraa_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = oraa_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS  = oraa_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  // Configuration: deviation_ratio, Q4.8 of the average.
  input  wire logic                                         cfg_we,
  input  wire logic [oraa_pkg::RATIO_BITS-1:0]              cfg_wdata,
  // Input items. tdata: sample.
  input  wire logic                                         s_tvalid,
  output logic                                              s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]             s_tdata,
  // Result items. tdata: average, sample_count. tuser: restarted.
  output logic                                              m_tvalid,
  input  wire logic                                         m_tready,
  output logic [((SAMPLE_BITS+oraa_pkg::AVG_SHIFT+COUNT_BITS+7)/8)*8-1:0] m_tdata,
  output logic                                              m_tuser
);

  import oraa_pkg::*;

  localparam int AVG_BITS   = SAMPLE_BITS + AVG_SHIFT;
  localparam int LHS_BITS   = AVG_BITS + FRAC_BITS;
  localparam int PROD_BITS  = AVG_BITS + RATIO_BITS;
  localparam int CMP_BITS   = (LHS_BITS > PROD_BITS) ? LHS_BITS : PROD_BITS;

  ctrl_t                  ctl;
  logic [RATIO_BITS-1:0]  ratio;
  logic [AVG_BITS-1:0]    avg;
  logic [COUNT_BITS-1:0]  count;
  logic                   restarted;
  logic [AVG_BITS-1:0]    s_ext;
  logic [AVG_BITS-1:0]    mag;
  logic                   up;
  logic [LHS_BITS-1:0]    lhs;
  logic [PROD_BITS-1:0]   prod;
  logic [AVG_BITS-1:0]    sample_q;
  logic                   restart_now;
  logic [COUNT_BITS-1:0]  n_next;
  logic                   div_done;
  logic [AVG_BITS-1:0]    quotient;

  // Sequencer.
  oraa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .restart  (restart_now),
    .div_done (div_done),
    .ctl      (ctl)
  );

  assign s_tready = ctl.s_ready;
  assign m_tvalid = ctl.m_valid;

  // Deviation ratio register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      ratio <= cfg_wdata;
    end
  end

  // Sample moved into the average domain.
  assign s_ext = {s_tdata[SAMPLE_BITS-1:0], {AVG_SHIFT{1'b0}}};

  // Capture the sample and its distance from the average on acceptance.
  always_ff @(posedge clk) begin
    if (s_tvalid && ctl.s_ready) begin
      sample_q <= s_ext;
      up       <= (s_ext >= avg);
      mag      <= (s_ext >= avg) ? (s_ext - avg) : (avg - s_ext);
    end
  end

  // Threshold product and scaled deviation.
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= PROD_BITS'(ratio) * PROD_BITS'(avg);
      lhs  <= LHS_BITS'(mag) << FRAC_BITS;
    end
  end

  // Outlier test and the divisor for an ordinary update.
  assign restart_now = (avg == '0) || (CMP_BITS'(lhs) > CMP_BITS'(prod));
  assign n_next      = (count == '1) ? count : count + 1'b1;

  // Divider for the averaging step.
  oraa_div #(
    .DIVIDEND_BITS (AVG_BITS),
    .DIVISOR_BITS  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.decide && !restart_now),
    .dividend (mag),
    .divisor  (n_next),
    .done     (div_done),
    .quotient (quotient)
  );

  // Running average and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg   <= '0;
      count <= '0;
    end else if (ctl.decide) begin
      if (restart_now) begin
        avg   <= sample_q;
        count <= COUNT_BITS'(1);
      end else begin
        count <= n_next;
      end
    end else if (ctl.update) begin
      avg <= up ? (avg + quotient) : (avg - quotient);
    end
  end

  // Restart flag of the current result.
  always_ff @(posedge clk) begin
    if (ctl.decide) begin
      restarted <= restart_now;
    end
  end

  // Result packing: average in the low bits, then the count.
  always_comb begin
    m_tdata                          = '0;
    m_tdata[AVG_BITS-1:0]            = avg;
    m_tdata[AVG_BITS +: COUNT_BITS]  = count;
  end

  assign m_tuser = restarted;

  // A result always counts at least one sample.
  `ORAA_ASSERT_ALWAYS(a_count_nonzero, clk, rst, !m_tvalid || (count != '0), "result with zero sample count")

  // A restarted average holds exactly one sample.
  `ORAA_ASSERT_ALWAYS(a_restart_count, clk, rst, !(m_tvalid && m_tuser) || (count == COUNT_BITS'(1)), "restart without count of one")

  // The block never takes an item while a result is pending.
  `ORAA_ASSERT_ALWAYS(a_one_item, clk, rst, !(s_tready && m_tvalid), "input ready while result pending")

  // After an item is accepted the input side closes.
  `ORAA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

endmodule

`default_nettype wire
